/* rtl/core/sbrc_pkg.sv */
// Shared types and constants for the sequential block run coalescer.
// No dependencies; used by every module in rtl/core.
package sbrc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LIST_DEF  = 1048576;
    localparam int RUN_CAP_DEF   = 1024;
    localparam int ADDR_BITS_DEF = 48;

    // Fixed field widths
    localparam int SECTOR_W  = 48;
    localparam int INDEX_W   = 20;
    localparam int BLOCKS_W  = 11;
    localparam int MAX_RUN_W = 11;

    // One 4 KiB block spans this many 512-byte sectors
    localparam int SECTORS_PER_BLOCK = 8;

    // Entries in the front-to-back queue (power of two)
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector_addr;
        logic                is_write;
        logic                list_end;
    } t_sbrc_in;

    typedef struct packed {
        logic [INDEX_W-1:0]  run_index;
        logic [SECTOR_W-1:0] run_sector;
        logic [BLOCKS_W-1:0] run_blocks;
        logic                run_write;
        logic                final_run;
    } t_sbrc_out;

    // Up to two runs produced by one request: a closed run, then the final run
    typedef struct packed {
        logic      a_vld;
        t_sbrc_out a;
        logic      b_vld;
        t_sbrc_out b;
    } t_sbrc_entry;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } t_sbrc_phase;

endpackage

/* rtl/core/sbrc_front.sv */
// Front end: accepts requests, tracks the open run and classifies each request.
// Pushes the runs it closes into the queue. Depends on sbrc_pkg.
module sbrc_front #(
    parameter int MAX_LIST  = sbrc_pkg::MAX_LIST_DEF,
    parameter int RUN_CAP   = sbrc_pkg::RUN_CAP_DEF,
    parameter int ADDR_BITS = sbrc_pkg::ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbrc_pkg::MAX_RUN_W-1:0]   i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sbrc_pkg::t_sbrc_in               i_in_item,
    input  logic                             i_full,
    output logic                             o_push,
    output sbrc_pkg::t_sbrc_entry            o_entry
);

    localparam int AW    = (ADDR_BITS < sbrc_pkg::SECTOR_W) ? ADDR_BITS : sbrc_pkg::SECTOR_W;
    localparam int CNT_W = $clog2(MAX_LIST);
    localparam int LEN_W = $clog2(RUN_CAP + 1);
    localparam int LW    = (LEN_W > sbrc_pkg::MAX_RUN_W) ? LEN_W : sbrc_pkg::MAX_RUN_W;

    logic [AW-1:0]    r_prev_sector;
    logic             r_prev_dir;
    logic [CNT_W-1:0] r_start_idx;
    logic [AW-1:0]    r_start_sector;
    logic [LEN_W-1:0] r_open_len;
    logic [CNT_W-1:0] r_count;
    logic [LEN_W-1:0] r_limit;

    logic [CNT_W-1:0] n_start_idx;
    logic [AW-1:0]    n_start_sector;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] n_open_len;
    logic [CNT_W-1:0] n_count;
    logic [LEN_W-1:0] n_limit;

    logic                 accept;
    logic [AW-1:0]        addr;
    logic [ADDR_BITS-1:0] diff;
    logic                 open_run;
    logic                 extend;
    logic [LW-1:0]        cfg_ext;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign addr       = i_in_item.sector_addr[AW-1:0];
    // wraps modulo 2^ADDR_BITS
    assign diff       = ADDR_BITS'(addr) - ADDR_BITS'(r_prev_sector);
    assign open_run   = (r_open_len != '0);
    assign extend     = open_run
                        && (diff == ADDR_BITS'(sbrc_pkg::SECTORS_PER_BLOCK))
                        && (i_in_item.is_write == r_prev_dir)
                        && (r_open_len < r_limit);

    // Clamp the run limit into 1..RUN_CAP when it is written
    always_comb begin
        cfg_ext = LW'(i_cfg_wdata);
        if (cfg_ext == '0) begin
            n_limit = LEN_W'(1);
        end else if (cfg_ext > LW'(RUN_CAP)) begin
            n_limit = LEN_W'(RUN_CAP);
        end else begin
            n_limit = LEN_W'(cfg_ext);
        end
    end

    always_comb begin
        if (extend) begin
            n_start_idx    = r_start_idx;
            n_start_sector = r_start_sector;
            n_len          = r_open_len + LEN_W'(1);
        end else begin
            n_start_idx    = r_count;
            n_start_sector = addr;
            n_len          = LEN_W'(1);
        end

        if (i_in_item.list_end || (r_count == CNT_W'(MAX_LIST - 1))) begin
            n_count = '0;
        end else begin
            n_count = r_count + CNT_W'(1);
        end

        n_open_len = i_in_item.list_end ? '0 : n_len;
    end

    always_comb begin
        o_entry.a_vld          = open_run && !extend;
        o_entry.a.run_index    = sbrc_pkg::INDEX_W'(r_start_idx);
        o_entry.a.run_sector   = sbrc_pkg::SECTOR_W'(r_start_sector);
        o_entry.a.run_blocks   = sbrc_pkg::BLOCKS_W'(r_open_len);
        o_entry.a.run_write    = r_prev_dir;
        o_entry.a.final_run    = 1'b0;

        o_entry.b_vld          = i_in_item.list_end;
        o_entry.b.run_index    = sbrc_pkg::INDEX_W'(n_start_idx);
        o_entry.b.run_sector   = sbrc_pkg::SECTOR_W'(n_start_sector);
        o_entry.b.run_blocks   = sbrc_pkg::BLOCKS_W'(n_len);
        o_entry.b.run_write    = i_in_item.is_write;
        o_entry.b.final_run    = 1'b1;
    end

    assign o_push = accept && (o_entry.a_vld || o_entry.b_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_len <= '0;
            r_count    <= '0;
            r_limit    <= LEN_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_limit <= n_limit;
            end
            if (accept) begin
                r_open_len <= n_open_len;
                r_count    <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_sector  <= addr;
            r_prev_dir     <= i_in_item.is_write;
            r_start_idx    <= n_start_idx;
            r_start_sector <= n_start_sector;
        end
    end

    // The list end always closes the run and rewinds the list position
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_item.list_end |=> (r_open_len == '0) && (r_count == '0))
        else $error("run still open after list end");

    // A request that merges never produces a closed run
    a_extend_no_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        extend |-> !o_entry.a_vld)
        else $error("closed run emitted on an extending request");

endmodule

/* rtl/core/sbrc_queue.sv */
// Short FIFO of classified entries between the front and back ends.
// Depends on sbrc_pkg.
module sbrc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sbrc_pkg::t_sbrc_entry i_entry,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output sbrc_pkg::t_sbrc_entry o_head
);

    localparam int DEPTH = sbrc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sbrc_pkg::t_sbrc_entry r_slot [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_fill;

    assign o_full  = (r_fill == CNT_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + CNT_W'(1);
                2'b01:   r_fill <= r_fill - CNT_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

/* rtl/core/sbrc_back.sv */
// Back end: drains queue entries one run per cycle into the output register while it is not stalled.
// Depends on sbrc_pkg.
module sbrc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  sbrc_pkg::t_sbrc_entry i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sbrc_pkg::t_sbrc_out   o_out_item
);

    sbrc_pkg::t_sbrc_phase r_phase;
    sbrc_pkg::t_sbrc_phase n_phase;
    logic                  r_out_valid;
    sbrc_pkg::t_sbrc_out   r_out;

    logic                  load;
    logic                  take_a;
    sbrc_pkg::t_sbrc_out   sel;

    assign load = !i_empty && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            sbrc_pkg::PH_FIRST: begin
                if (load && i_head.a_vld && i_head.b_vld) begin
                    n_phase = sbrc_pkg::PH_SECOND;
                end
            end
            sbrc_pkg::PH_SECOND: begin
                if (load) begin
                    n_phase = sbrc_pkg::PH_FIRST;
                end
            end
            default: n_phase = sbrc_pkg::PH_FIRST;
        endcase
    end

    // outputs of the phase machine
    always_comb begin
        case (r_phase)
            sbrc_pkg::PH_FIRST:  take_a = i_head.a_vld;
            sbrc_pkg::PH_SECOND: take_a = 1'b0;
            default:             take_a = 1'b0;
        endcase
        sel   = take_a ? i_head.a : i_head.b;
        o_pop = load && (!take_a || !i_head.b_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sbrc_pkg::PH_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= sel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Second half only exists for an entry that carries a final run
    a_second_has_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sbrc_pkg::PH_SECOND) |-> (!i_empty && i_head.b_vld))
        else $error("second phase without a pending final run");

    a_nonempty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.run_blocks != '0))
        else $error("emitted run has no blocks");

endmodule

/* rtl/core/sequential_block_run_coalescer_unit.sv */
// Top level of the sequential block run coalescer.
// Instantiates sbrc_front, sbrc_queue and sbrc_back; depends on sbrc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one 4 KiB
//   block request per transaction: sector address, direction, list-end flag.
//   Output channel (o_out_valid / i_out_stall / o_out_item) carries one run
//   hint per transaction: start index, start sector, block count, direction,
//   final flag. A request yields zero, one or two runs; a closed run always
//   precedes the final run of the same request.
//   i_cfg_we / i_cfg_wdata write max_run, the run length limit (0 acts as 1,
//   values above RUN_CAP act as RUN_CAP). Write it only while no transaction
//   is in flight.
// Timing:
//   One request per cycle while the queue is not full. A run is registered in
//   a queue slot and then in the output register; a request giving two runs
//   keeps the back end busy for both, and the four-entry queue between the
//   front and back ends absorbs that. The front end's compare-and-update loop
//   on the open run sets the input rate.
// Reset (synchronous, active low): no run open, list position 0, max_run 1,
//   queue and output register empty.
// Stall: the output register holds its run; the queue fills behind it and
//   o_in_stall rises once the queue is full.
module sequential_block_run_coalescer_unit #(
    parameter int MAX_LIST  = sbrc_pkg::MAX_LIST_DEF,
    parameter int RUN_CAP   = sbrc_pkg::RUN_CAP_DEF,
    parameter int ADDR_BITS = sbrc_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbrc_pkg::MAX_RUN_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sbrc_pkg::t_sbrc_in             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sbrc_pkg::t_sbrc_out            o_out_item
);

    // front-to-queue
    logic                  push;
    sbrc_pkg::t_sbrc_entry push_entry;
    // queue-to-back
    logic                  q_full;
    logic                  q_empty;
    logic                  pop;
    sbrc_pkg::t_sbrc_entry head;

    // Front end: classifies each request against the open run
    sbrc_front #(
        .MAX_LIST  (MAX_LIST),
        .RUN_CAP   (RUN_CAP),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_full      (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // Decoupling queue: only requests that produce runs take an entry
    sbrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // Back end: serializes up to two runs per entry into the output register
    sbrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* tb/sv/tb_sequential_block_run_coalescer_unit.sv */
// Self-checking testbench for sequential_block_run_coalescer_unit: block requests in,
// run hints out, checked against an in-bench run predictor.
// Depends on sbrc_pkg and the RTL under rtl/core.
module tb_sequential_block_run_coalescer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no transaction on either channel before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // Front end to output register goes through the queue; give it margin
    localparam int DRAIN_CYCLES = 8;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [sbrc_pkg::MAX_RUN_W-1:0] cfg_wdata = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    sbrc_pkg::t_sbrc_in             in_item = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    sbrc_pkg::t_sbrc_out            out_item;

    // Requests waiting for the driver, and run hints the predictor still owes
    sbrc_pkg::t_sbrc_in  req_backlog[$];
    sbrc_pkg::t_sbrc_out runs_due[$];
    int unsigned reqs_queued = 0;
    int unsigned reqs_taken = 0;
    int unsigned mismatches = 0;
    int unsigned dead_cycles = 0;
    logic        in_fire = 1'b0;  // request transaction taken at the last rising edge
    bit          quiet = 1'b0;    // no gaps and no stalls while set

    // Predictor state: the open run and the list position, plus the max_run register
    logic [sbrc_pkg::SECTOR_W-1:0]  last_sector = '0;
    logic                           last_write = 1'b0;
    logic [sbrc_pkg::INDEX_W-1:0]   open_idx = '0;
    logic [sbrc_pkg::SECTOR_W-1:0]  open_sector = '0;
    logic [sbrc_pkg::BLOCKS_W-1:0]  open_len = '0;     // zero: no run open
    logic [sbrc_pkg::INDEX_W-1:0]   list_pos = '0;
    logic [sbrc_pkg::MAX_RUN_W-1:0] max_run_cfg = 1;

    sequential_block_run_coalescer_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Run predictor
    // ------------------------------------------------------------------

    // Closed runs report the direction of the request that opened them, which is
    // still held in last_write when the break is seen.
    function automatic void close_run(logic fin);
        sbrc_pkg::t_sbrc_out hint;
        hint.run_index  = open_idx;
        hint.run_sector = open_sector;
        hint.run_blocks = open_len;
        hint.run_write  = last_write;
        hint.final_run  = fin;
        runs_due.push_back(hint);
    endfunction

    function automatic void coalesce_request(sbrc_pkg::t_sbrc_in req);
        logic [sbrc_pkg::SECTOR_W-1:0] stride;
        logic [sbrc_pkg::BLOCKS_W-1:0] cap;
        logic                          joins;
        // Limit of zero behaves as one; anything past RUN_CAP is clamped
        if (max_run_cfg == 0)
            cap = 1;
        else if (max_run_cfg > sbrc_pkg::RUN_CAP_DEF)
            cap = sbrc_pkg::BLOCKS_W'(sbrc_pkg::RUN_CAP_DEF);
        else
            cap = max_run_cfg;
        // Address step wraps at the sector width (ADDR_BITS equals SECTOR_W here)
        stride = req.sector_addr - last_sector;
        joins = (open_len != 0) &&
                (stride == sbrc_pkg::SECTOR_W'(sbrc_pkg::SECTORS_PER_BLOCK)) &&
                (req.is_write == last_write) && (open_len < cap);
        if (open_len != 0 && !joins)
            close_run(1'b0);
        if (joins) begin
            open_len++;
        end else begin
            open_idx    = list_pos;
            open_sector = req.sector_addr;
            open_len    = 1;
        end
        last_sector = req.sector_addr;
        last_write  = req.is_write;
        list_pos++;  // 20-bit counter wraps exactly at MAX_LIST
        if (req.list_end) begin
            close_run(1'b1);
            open_len = 0;
            list_pos = 0;
        end
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge: predictor, output check, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        sbrc_pkg::t_sbrc_out want;
        if (rst_n) begin
            if (cfg_we)
                max_run_cfg = cfg_wdata;
            if (in_valid && !in_stall) begin
                coalesce_request(in_item);
                reqs_taken++;
            end
            if (out_valid && !out_stall) begin
                if (runs_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected run idx=%0d sector=%h blocks=%0d",
                                    out_item.run_index, out_item.run_sector,
                                    out_item.run_blocks));
                end else begin
                    want = runs_due.pop_front();
                    if (out_item.run_index !== want.run_index)
                        report_mismatch($sformatf("run_index got %0d want %0d",
                                        out_item.run_index, want.run_index));
                    if (out_item.run_sector !== want.run_sector)
                        report_mismatch($sformatf("run_sector got %h want %h",
                                        out_item.run_sector, want.run_sector));
                    if (out_item.run_blocks !== want.run_blocks)
                        report_mismatch($sformatf("run_blocks got %0d want %0d",
                                        out_item.run_blocks, want.run_blocks));
                    if (out_item.run_write !== want.run_write)
                        report_mismatch($sformatf("run_write got %b want %b",
                                        out_item.run_write, want.run_write));
                    if (out_item.final_run !== want.final_run)
                        report_mismatch($sformatf("final_run got %b want %b",
                                        out_item.final_run, want.final_run));
                end
            end
        end
        in_fire <= rst_n && in_valid && !in_stall;
        // Watchdog: any transaction on either channel counts as progress
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
            dead_cycles = 0;
        end else begin
            dead_cycles++;
            if (dead_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving at the falling edge
    // ------------------------------------------------------------------

    // Request driver: a payload that was not taken stays on the bus unchanged
    always @(negedge clk) begin
        if (rst_n && !(in_valid && !in_fire)) begin
            if (req_backlog.size() != 0 && (quiet || $urandom_range(99) >= 28)) begin
                in_item  <= req_backlog.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Run hint receiver: random back-pressure
    always @(negedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 28);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_req(logic [sbrc_pkg::SECTOR_W-1:0] sec, logic wr, logic last);
        sbrc_pkg::t_sbrc_in req;
        req.sector_addr = sec;
        req.is_write    = wr;
        req.list_end    = last;
        req_backlog.push_back(req);
        reqs_queued++;
    endtask

    // Biased toward both address extremes so the wrap of the step is hit often
    function automatic logic [sbrc_pkg::SECTOR_W-1:0] pick_sector();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(7))
            0:       return {sbrc_pkg::SECTOR_W{1'b1}} -
                            sbrc_pkg::SECTOR_W'($urandom_range(40));
            1:       return sbrc_pkg::SECTOR_W'($urandom_range(64));
            default: return raw[sbrc_pkg::SECTOR_W-1:0];
        endcase
    endfunction

    // One request list: mostly sequential blocks in one direction, broken by
    // direction flips, gaps, back-steps, repeats and random jumps.
    task automatic queue_list(int n, bit closed);
        logic [sbrc_pkg::SECTOR_W-1:0] sec;
        logic                          wr;
        sec = pick_sector();
        wr  = 1'($urandom_range(1));
        for (int k = 0; k < n; k++) begin
            if (k > 0) begin
                case ($urandom_range(19))
                    0, 1: begin
                        sec = pick_sector();
                        wr  = 1'($urandom_range(1));
                    end
                    2: begin
                        sec += sbrc_pkg::SECTOR_W'(sbrc_pkg::SECTORS_PER_BLOCK);
                        wr  = ~wr;
                    end
                    3:       sec += sbrc_pkg::SECTOR_W'(2 * sbrc_pkg::SECTORS_PER_BLOCK);
                    4:       sec -= sbrc_pkg::SECTOR_W'(sbrc_pkg::SECTORS_PER_BLOCK);
                    5:       sec = sec;
                    6:       sec += sbrc_pkg::SECTOR_W'($urandom_range(1, 7));
                    default: sec += sbrc_pkg::SECTOR_W'(sbrc_pkg::SECTORS_PER_BLOCK);
                endcase
            end
            queue_req(sec, wr, closed && (k == n - 1));
        end
    endtask

    task automatic random_phase(int budget);
        int done;
        int len;
        done = 0;
        while (done < budget) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            // Now and then the list is left open across the next register write
            queue_list(len, $urandom_range(15) != 0);
            done += len;
        end
    endtask

    // Wait for every request to be taken and every run hint to arrive. A request
    // that only extended a run leaves no trace at the output, so allow the pipe
    // a few more cycles before touching the register.
    task automatic settle();
        while (reqs_taken != reqs_queued || runs_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_max_run(logic [sbrc_pkg::MAX_RUN_W-1:0] value);
        settle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [sbrc_pkg::MAX_RUN_W-1:0] limit_plan[$];

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit of one: every request is its own run
        queue_req('0, 1'b0, 1'b1);                        // single-request list
        queue_req(48'hFFFF_FFFF_FFF8, 1'b1, 1'b0);
        queue_req('0, 1'b1, 1'b0);
        queue_req(48'h0000_0000_0008, 1'b1, 1'b1);

        // Limit register of zero behaves as one
        write_max_run('0);
        queue_req(48'd100, 1'b0, 1'b0);
        queue_req(48'd108, 1'b0, 1'b1);

        // Limit of four: wrap-around extension, limit break, direction break,
        // extend on the list end, break on the list end
        write_max_run(11'd4);
        queue_req(48'hFFFF_FFFF_FFF8, 1'b1, 1'b0);
        queue_req(48'd0, 1'b1, 1'b0);
        queue_req(48'd8, 1'b1, 1'b0);
        queue_req(48'd16, 1'b1, 1'b0);
        queue_req(48'd24, 1'b1, 1'b0);
        queue_req(48'd32, 1'b0, 1'b0);
        queue_req(48'd40, 1'b0, 1'b0);
        queue_req(48'd48, 1'b0, 1'b1);
        queue_req({sbrc_pkg::SECTOR_W{1'b1}}, 1'b0, 1'b0);
        queue_req(48'd100, 1'b0, 1'b1);
        queue_req(48'd500, 1'b1, 1'b0);                   // left open over the write

        // Register all ones clamps to RUN_CAP: the open run grows to the cap.
        // Both channels run flat out for this long stretch.
        write_max_run({sbrc_pkg::MAX_RUN_W{1'b1}});
        quiet = 1'b1;
        for (int k = 1; k <= 1026; k++)
            queue_req(sbrc_pkg::SECTOR_W'(500 + 8 * k), 1'b1, k == 1026);

        // Random lists under a spread of limits
        limit_plan = '{11'd3, 11'd1024, 11'd1, 11'd0, {sbrc_pkg::MAX_RUN_W{1'b1}},
                       sbrc_pkg::MAX_RUN_W'($urandom_range(2047)),
                       sbrc_pkg::MAX_RUN_W'($urandom_range(1, 16)),
                       11'd2};
        foreach (limit_plan[p]) begin
            write_max_run(limit_plan[p]);
            quiet = 1'b0;
            random_phase(6);
        end

        settle();
        quiet = 1'b0;
        repeat (16) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
